FILE: rtl/core/slps_pkg.sv
// Shared types, codes and constants of the status LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none
package slps_pkg;
	localparam int DUTY_BITS_DEF = 8;

	typedef logic [2:0] ovl_t;
	localparam ovl_t OVL_NONE  = 3'd0;
	localparam ovl_t OVL_BOOT  = 3'd1;
	localparam ovl_t OVL_ERR   = 3'd2;
	localparam ovl_t OVL_BAT   = 3'd3;
	localparam ovl_t OVL_MEAS  = 3'd4;
	localparam ovl_t OVL_PREP  = 3'd5;

	typedef logic [3:0] req_t;
	localparam req_t REQ_TICK   = 4'd0;
	localparam req_t REQ_BOOT   = 4'd1;
	localparam req_t REQ_ERR    = 4'd2;
	localparam req_t REQ_BAT    = 4'd3;
	localparam req_t REQ_MEAS   = 4'd4;
	localparam req_t REQ_COMM   = 4'd5;
	localparam req_t REQ_SENSOR = 4'd6;
	localparam req_t REQ_PREP   = 4'd7;
	localparam req_t REQ_RESET  = 4'd8;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BOOT_CNT   = 3'd0;
	localparam cfg_idx_t CFG_BOOT_ON    = 3'd1;
	localparam cfg_idx_t CFG_BOOT_OFF   = 3'd2;
	localparam cfg_idx_t CFG_ERR_TOTAL  = 3'd3;
	localparam cfg_idx_t CFG_ERR_STEP   = 3'd4;
	localparam cfg_idx_t CFG_COMM_HALF  = 3'd5;
	localparam cfg_idx_t CFG_SENSOR_ON  = 3'd6;
	localparam cfg_idx_t CFG_SENSOR_OFF = 3'd7;

	localparam logic [15:0] MEAS_ON_MS     = 16'd10;
	localparam logic [15:0] BAT_PULSE_MS   = 16'd100;
	localparam logic [15:0] BAT_FULL_ON_MS = 16'd5000;
	localparam logic [15:0] BAT_SEG_MS     = 16'd1000;
	localparam logic [3:0]  BAT_MAX_SEG    = 4'd9;
	localparam logic [6:0]  PCT_MAX        = 7'd100;
	localparam int          PREP_DIR_MS    = 300;
	// level / 10 as (level * 205) >> 11, exact for levels up to 100
	localparam logic [7:0]  DIV10_MUL      = 8'd205;

	typedef struct packed {
		logic [3:0]  boot_cnt;
		logic [15:0] boot_on;
		logic [15:0] boot_off;
		logic [15:0] err_total;
		logic [7:0]  err_step;
		logic [15:0] comm_half;
		logic [15:0] sensor_on;
		logic [15:0] sensor_off;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		boot_cnt: 4'd3, boot_on: 16'd1000, boot_off: 16'd100,
		err_total: 16'd60000, err_step: 8'd20, comm_half: 16'd250,
		sensor_on: 16'd2000, sensor_off: 16'd1000
	};

	typedef struct packed {
		ovl_t        overlay;
		logic        comm;
		logic        sensor;
		logic [6:0]  bat_level;
		logic [31:0] prep_total;
		logic [2:0]  phase;
		logic [15:0] pticks;
		logic [31:0] elapsed;
		logic [8:0]  dir;
		logic [3:0]  rep;
		logic        fade_down;
	} pat_t;
endpackage
`default_nettype wire

FILE: rtl/core/slps_next.sv
// Next-state and duty logic for one item of the LED pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none
module slps_next #(
	parameter int DUTY_BITS = slps_pkg::DUTY_BITS_DEF
) (
	input  wire slps_pkg::pat_t  cur,
	input  wire [DUTY_BITS-1:0]  lvl_cur,
	input  wire slps_pkg::cfg_t  cfg,
	input  wire slps_pkg::req_t  req,
	input  wire [7:0]            pct,
	input  wire                  flag,
	input  wire [31:0]           dur,
	output slps_pkg::pat_t       nxt,
	output logic [DUTY_BITS-1:0] lvl_nxt,
	output logic [7:0]           duty,
	output logic                 err_done
);
	localparam logic [DUTY_BITS-1:0] DMAX = '1;
	localparam int STEPS   = 1 << DUTY_BITS;
	localparam int PD_BASE = slps_pkg::PREP_DIR_MS / STEPS;
	localparam int PD_REM  = slps_pkg::PREP_DIR_MS % STEPS;

	function automatic logic [15:0] bg_len(input logic sensor, input logic comm,
		input logic ph, input slps_pkg::cfg_t c);
		if (sensor)
			return ph ? c.sensor_off : c.sensor_on;
		else if (comm)
			return c.comm_half;
		else
			return 16'd0;
	endfunction

	function automatic logic bg_live(input logic sensor, input logic comm,
		input slps_pkg::cfg_t c);
		return (bg_len(sensor, comm, 1'b0, c) | bg_len(sensor, comm, 1'b1, c)) != 16'd0;
	endfunction

	slps_pkg::pat_t st;
	logic [DUTY_BITS-1:0] lvl, idx;
	logic [DUTY_BITS-1:0] dv;
	logic do_settle, end_ovl, end2;
	logic [16:0] pt_inc;
	logic [32:0] el_inc;
	logic [8:0]  dir_inc;
	logic [15:0] seg_cur;
	logic [14:0] prod;
	logic [3:0]  segs;
	logic [9:0]  dstep;
	logic        at_edge;

	always_comb begin
		prod = 15'(cur.bat_level) * 15'(slps_pkg::DIV10_MUL);
		segs = (prod[14:11] > slps_pkg::BAT_MAX_SEG) ? slps_pkg::BAT_MAX_SEG : prod[14:11];
		idx  = cur.fade_down ? DMAX - lvl_cur : lvl_cur;
		dstep = 10'(PD_BASE) + ((32'(idx) < PD_REM) ? 10'd1 : 10'd0);
		if (dstep == 10'd0)
			dstep = 10'd1;
		pt_inc  = {1'b0, cur.pticks} + 17'd1;
		el_inc  = {1'b0, cur.elapsed} + 33'd1;
		dir_inc = cur.dir + 9'd1;
		at_edge = lvl_cur == (cur.fade_down ? '0 : DMAX);

		// length of the current phase for tick-driven overlays and background
		unique case (cur.overlay)
			slps_pkg::OVL_BOOT:
				seg_cur = (cur.rep >= cfg.boot_cnt) ? 16'd0 :
					(cur.phase == 3'd0 ? cfg.boot_on : cfg.boot_off);
			slps_pkg::OVL_BAT: begin
				if (cur.phase == 3'd2)
					seg_cur = (cur.bat_level >= slps_pkg::PCT_MAX) ?
						slps_pkg::BAT_FULL_ON_MS : slps_pkg::BAT_SEG_MS;
				else if (cur.phase == 3'd3 || cur.phase == 3'd4)
					seg_cur = slps_pkg::BAT_SEG_MS;
				else
					seg_cur = slps_pkg::BAT_PULSE_MS;
			end
			slps_pkg::OVL_MEAS:
				seg_cur = (cur.phase == 3'd0) ? slps_pkg::MEAS_ON_MS : 16'd0;
			default:
				seg_cur = bg_len(cur.sensor, cur.comm, cur.phase[0], cfg);
		endcase

		st = cur;
		lvl = lvl_cur;
		do_settle = 1'b0;
		end_ovl = 1'b0;
		end2 = 1'b0;
		err_done = 1'b0;

		case (req)
			slps_pkg::REQ_TICK: begin
				unique case (cur.overlay)
					slps_pkg::OVL_ERR: begin
						st.elapsed = el_inc[31:0];
						st.pticks = pt_inc[15:0];
						if (el_inc >= {17'd0, cfg.err_total}) begin
							err_done = 1'b1;
							end_ovl = 1'b1;
							do_settle = 1'b1;
						end else if (pt_inc >= {9'd0, cfg.err_step}) begin
							st.pticks = 16'd0;
							if (!cur.fade_down) begin
								if (lvl_cur == DMAX) st.fade_down = 1'b1;
								else lvl = lvl_cur + 1'b1;
							end else begin
								if (lvl_cur == '0) st.fade_down = 1'b0;
								else lvl = lvl_cur - 1'b1;
							end
						end
					end
					slps_pkg::OVL_PREP: begin
						st.elapsed = el_inc[31:0];
						st.dir = dir_inc;
						st.pticks = pt_inc[15:0];
						if (el_inc >= {1'b0, cur.prep_total}) begin
							end_ovl = 1'b1;
							do_settle = 1'b1;
						end else if (pt_inc >= 17'(dstep) ||
							dir_inc >= 9'(slps_pkg::PREP_DIR_MS)) begin
							st.pticks = 16'd0;
							if (dir_inc >= 9'(slps_pkg::PREP_DIR_MS) || at_edge) begin
								st.dir = 9'd0;
								st.fade_down = !cur.fade_down;
								lvl = cur.fade_down ? '0 : DMAX;
							end else if (cur.fade_down)
								lvl = lvl_cur - 1'b1;
							else
								lvl = lvl_cur + 1'b1;
						end
					end
					default: begin
						if (cur.overlay != slps_pkg::OVL_NONE ||
							bg_live(cur.sensor, cur.comm, cfg)) begin
							st.pticks = pt_inc[15:0];
							if (pt_inc >= {1'b0, seg_cur}) begin
								st.pticks = 16'd0;
								do_settle = 1'b1;
								unique case (cur.overlay)
									slps_pkg::OVL_BOOT: begin
										if (cur.rep >= cfg.boot_cnt)
											end_ovl = 1'b1;
										else if (cur.phase == 3'd0)
											st.phase = 3'd1;
										else begin
											st.phase = 3'd0;
											st.rep = cur.rep + 4'd1;
										end
									end
									slps_pkg::OVL_BAT: begin
										unique case (cur.phase)
											3'd0: st.phase = 3'd1;
											3'd1: begin
												st.rep = 4'd0;
												st.phase = (cur.bat_level >= slps_pkg::PCT_MAX ||
													segs != 4'd0) ? 3'd2 : 3'd4;
											end
											3'd2: st.phase = 3'd3;
											3'd3: begin
												if (cur.bat_level >= slps_pkg::PCT_MAX)
													st.phase = 3'd5;
												else begin
													st.rep = cur.rep + 4'd1;
													st.phase = (st.rep >= segs) ? 3'd5 : 3'd2;
												end
											end
											3'd4: st.phase = 3'd5;
											3'd5: st.phase = 3'd6;
											default: end_ovl = 1'b1;
										endcase
									end
									slps_pkg::OVL_MEAS: begin
										if (cur.phase == 3'd0) st.phase = 3'd1;
										else end_ovl = 1'b1;
									end
									default: st.phase = (cur.phase == 3'd0) ? 3'd1 : 3'd0;
								endcase
							end
						end
					end
				endcase
			end
			slps_pkg::REQ_BOOT:   begin st.overlay = slps_pkg::OVL_BOOT; do_settle = 1'b1; end
			slps_pkg::REQ_ERR:    begin st.overlay = slps_pkg::OVL_ERR;  do_settle = 1'b1; end
			slps_pkg::REQ_BAT: begin
				st.bat_level = (pct > 8'(slps_pkg::PCT_MAX)) ? slps_pkg::PCT_MAX : pct[6:0];
				st.overlay = slps_pkg::OVL_BAT;
				do_settle = 1'b1;
			end
			slps_pkg::REQ_MEAS:   begin st.overlay = slps_pkg::OVL_MEAS; do_settle = 1'b1; end
			slps_pkg::REQ_COMM:   begin st.comm = flag; do_settle = 1'b1; end
			slps_pkg::REQ_SENSOR: begin st.sensor = flag; do_settle = 1'b1; end
			slps_pkg::REQ_PREP: begin
				if (dur != 32'd0) begin
					st.prep_total = dur;
					st.overlay = slps_pkg::OVL_PREP;
					do_settle = 1'b1;
				end
			end
			slps_pkg::REQ_RESET: begin
				st.comm = 1'b0;
				st.sensor = 1'b0;
				st.overlay = slps_pkg::OVL_NONE;
				st.bat_level = 7'd0;
				st.prep_total = 32'd0;
				do_settle = 1'b1;
			end
			default: ;
		endcase

		// commands restart the pattern from its start
		if (req != slps_pkg::REQ_TICK && do_settle) begin
			st.phase = 3'd0; st.pticks = 16'd0; st.elapsed = 32'd0; st.dir = 9'd0;
			st.rep = 4'd0; st.fade_down = 1'b0; lvl = '0;
		end

		if (end_ovl) begin
			if (st.overlay == slps_pkg::OVL_PREP) st.prep_total = 32'd0;
			st.overlay = slps_pkg::OVL_NONE;
			st.phase = 3'd0; st.pticks = 16'd0; st.elapsed = 32'd0; st.dir = 9'd0;
			st.rep = 4'd0; st.fade_down = 1'b0; lvl = '0;
		end

		// skip phases of zero length
		if (do_settle) begin
			unique case (st.overlay)
				slps_pkg::OVL_ERR:
					if (cfg.err_total == 16'd0 || cfg.err_step == 8'd0) begin
						err_done = 1'b1;
						end2 = 1'b1;
					end
				slps_pkg::OVL_PREP:
					end2 = st.prep_total == 32'd0;
				slps_pkg::OVL_BOOT: begin
					if (st.rep >= cfg.boot_cnt ||
						(cfg.boot_on == 16'd0 && cfg.boot_off == 16'd0))
						end2 = 1'b1;
					else if (st.phase == 3'd0) begin
						if (cfg.boot_on == 16'd0) st.phase = 3'd1;
					end else if (cfg.boot_off == 16'd0) begin
						if ({1'b0, st.rep} + 5'd1 >= {1'b0, cfg.boot_cnt})
							end2 = 1'b1;
						else begin
							st.phase = 3'd0;
							st.rep = st.rep + 4'd1;
						end
					end
				end
				slps_pkg::OVL_MEAS:
					end2 = st.phase != 3'd0;
				default: ;
			endcase
			if (end2) begin
				if (st.overlay == slps_pkg::OVL_PREP) st.prep_total = 32'd0;
				st.overlay = slps_pkg::OVL_NONE;
				st.phase = 3'd0; st.pticks = 16'd0; st.elapsed = 32'd0; st.dir = 9'd0;
				st.rep = 4'd0; st.fade_down = 1'b0; lvl = '0;
			end
			if (st.overlay == slps_pkg::OVL_NONE && bg_live(st.sensor, st.comm, cfg) &&
				bg_len(st.sensor, st.comm, st.phase[0], cfg) == 16'd0)
				st.phase = (st.phase == 3'd0) ? 3'd1 : 3'd0;
		end

		unique case (st.overlay)
			slps_pkg::OVL_BOOT, slps_pkg::OVL_MEAS:
				dv = (st.phase == 3'd0) ? DMAX : '0;
			slps_pkg::OVL_ERR, slps_pkg::OVL_PREP:
				dv = lvl;
			slps_pkg::OVL_BAT:
				dv = (st.phase == 3'd0 || st.phase == 3'd2 || st.phase == 3'd5) ? DMAX : '0;
			default:
				dv = (bg_live(st.sensor, st.comm, cfg) && st.phase == 3'd0) ? DMAX : '0;
		endcase

		nxt = st;
		lvl_nxt = lvl;
		duty = 8'(dv);
	end
endmodule
`default_nettype wire

FILE: rtl/core/status_led_pattern_sequencer.sv
// Top level of the status LED pattern sequencer: channels, state and config registers.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  s_* carries one item per transfer: a 1 ms tick or a command (boot, error
//  fade, battery, measure, comm/sensor flag, prep fade, reset).
//  m_* returns exactly one result item per input item: the LED duty after
//  that item, the active overlay and an error-fade completion flag.
//  cfg_* writes the eight timing registers; write only while no item is
//  in flight. New values apply from the next tick.
// Timing: the pattern state and the output register both load at the
//  accepting edge, so the result of each item is registered.
// Throughput: one item per cycle unless a held result stalls the input; the
//  next-state logic is a single pass between the state registers and the output register.
// Reset: arst_n clears the pattern state (no overlay, flags off, duty 0)
//  and loads the default timing registers.
// Stall: s_tready drops only while a result is held and m_tready is low;
//  the held result and the state stay put until it is taken.
module status_led_pattern_sequencer #(
	parameter int DUTY_BITS = slps_pkg::DUTY_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [3:0] req_type, [11:4] battery_percent, [12] active_flag,
	// [44:13] duration_ms, [47:45] zero
	input  wire  [47:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [7:0] duty, [10:8] overlay_code, [11] error_done, [15:12] zero
	output logic [15:0] m_tdata,
	input  wire         cfg_wr_en,
	input  wire  [2:0]  cfg_idx,
	input  wire  [15:0] cfg_wdata
);
	slps_pkg::pat_t pat_q, pat_nxt;
	logic [DUTY_BITS-1:0] lvl_q, lvl_nxt;
	slps_pkg::cfg_t cfg_q;
	logic [7:0] duty_nxt;
	logic err_nxt;
	logic in_acc;

	assign s_tready = !m_tvalid || m_tready;
	assign in_acc = s_tvalid && s_tready;

	slps_next #(.DUTY_BITS(DUTY_BITS)) u_next (
		.cur(pat_q),
		.lvl_cur(lvl_q),
		.cfg(cfg_q),
		.req(s_tdata[3:0]),
		.pct(s_tdata[11:4]),
		.flag(s_tdata[12]),
		.dur(s_tdata[44:13]),
		.nxt(pat_nxt),
		.lvl_nxt(lvl_nxt),
		.duty(duty_nxt),
		.err_done(err_nxt)
	);

	// pattern state advances only on accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			lvl_q <= '0;
		end else if (in_acc) begin
			pat_q <= pat_nxt;
			lvl_q <= lvl_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= slps_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				slps_pkg::CFG_BOOT_CNT:   cfg_q.boot_cnt <= cfg_wdata[3:0];
				slps_pkg::CFG_BOOT_ON:    cfg_q.boot_on <= cfg_wdata;
				slps_pkg::CFG_BOOT_OFF:   cfg_q.boot_off <= cfg_wdata;
				slps_pkg::CFG_ERR_TOTAL:  cfg_q.err_total <= cfg_wdata;
				slps_pkg::CFG_ERR_STEP:   cfg_q.err_step <= cfg_wdata[7:0];
				slps_pkg::CFG_COMM_HALF:  cfg_q.comm_half <= cfg_wdata;
				slps_pkg::CFG_SENSOR_ON:  cfg_q.sensor_on <= cfg_wdata;
				slps_pkg::CFG_SENSOR_OFF: cfg_q.sensor_off <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_acc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_tdata <= {4'd0, err_nxt, pat_nxt.overlay, duty_nxt};
		end
	end
endmodule
`default_nettype wire
